// ----- rtl/dle_stx_etx_frame_receiver_defines.svh -----
// assertion macros shared by the checker of the frame receiver
// depends on nothing; expects clk and rst_n in the scope of use
`ifndef DLE_STX_ETX_FRAME_RECEIVER_DEFINES_SVH
`define DLE_STX_ETX_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, idle during reset
`define DSEFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define DSEFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dsefr_pkg.sv -----
// shared constants, codes and types of the dle/stx/etx frame receiver
// depends on nothing
`timescale 1ns / 1ps

package dsefr_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CNT_W       = 7;
    localparam int BYTE_W      = 8;

    localparam logic [BYTE_W-1:0] CODE_STX = 8'h02;
    localparam logic [BYTE_W-1:0] CODE_ETX = 8'h03;
    localparam logic [BYTE_W-1:0] CODE_DLE = 8'h10;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_PAYLOAD);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_STX  = 2'd1,
        PH_DATA = 2'd2,
        PH_ESC  = 2'd3
    } rx_phase_t;

    typedef enum logic [1:0] {
        DR_IDLE = 2'd0,
        DR_READ = 2'd1,
        DR_SHOW = 2'd2
    } drain_state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] len;
    } drain_req_t;

endpackage

// ----- rtl/dle_stx_etx_frame_receiver.sv -----
// top level of the dle/stx/etx frame receiver
// depends on dsefr_pkg, dsefr_ram, dsefr_parser and dsefr_drain
`timescale 1ns / 1ps

// usage
//   input stream: one received byte per item, tdata[7:0] = rx_byte,
//   tuser = line_error (byte ignored, receiver back to hunting)
//   output stream: one item per payload byte of a frame closed by dle etx,
//   tdata[7:0] = byte, tdata[14:8] = frame length, tlast on the final byte,
//   tuser marks an empty frame (single item, byte reads zero)
// timing
//   ordinary bytes: one item per cycle while no frame drains, no output
//   dle etx: input stalls while the frame drains from the payload ram;
//   each output item takes a ram read state, then an output state, and
//   the next byte is read only after the previous item is taken
//   empty frame: marker in the cycle after the etx item
//   input ready returns in the cycle after the last output item is taken
// reset
//   rst_n low puts the receiver in hunt with a zero count; the payload ram
//   is not cleared, a frame only reads bytes written since its dle stx
// stall
//   a held output item holds its data; input stays stalled meanwhile
module dle_stx_etx_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tuser,   // line_error
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte, frame_length, zero pad
    output logic        m_axis_tlast,   // is_last
    output logic        m_axis_tuser    // is_empty
);
    import dsefr_pkg::*;

    drain_req_t        drain_req;
    logic              drain_busy;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    dsefr_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .rx_byte      (s_axis_tdata),
        .line_error   (s_axis_tuser),
        .drain_busy   (drain_busy),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .drain_req    (drain_req)
    );

    dsefr_ram #(
        .DATA_W(BYTE_W),
        .DEPTH (MAX_PAYLOAD),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    dsefr_drain u_drain (
        .clk          (clk),
        .rst_n        (rst_n),
        .drain_req    (drain_req),
        .drain_busy   (drain_busy),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

// ----- rtl/dsefr_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module dsefr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/dsefr_parser.sv -----
// receive-side phase machine: unstuffs bytes and writes the payload store
// depends on dsefr_pkg
`timescale 1ns / 1ps

module dsefr_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [dsefr_pkg::BYTE_W-1:0] rx_byte,
    input  logic                         line_error,
    input  logic                         drain_busy,
    output logic                         wr_en,
    output logic [dsefr_pkg::ADDR_W-1:0] wr_addr,
    output logic [dsefr_pkg::BYTE_W-1:0] wr_data,
    output dsefr_pkg::drain_req_t        drain_req
);
    import dsefr_pkg::*;

    rx_phase_t        phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             accept;

    assign s_axis_tready = !drain_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign wr_addr       = count_reg[ADDR_W-1:0];
    assign wr_data       = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        logic store;
        store           = 1'b0;
        phase_next      = phase_reg;
        count_next      = count_reg;
        wr_en           = 1'b0;
        drain_req.start = 1'b0;
        drain_req.len   = count_reg;
        if (accept)
        begin
            if (line_error)
            begin
                phase_next = PH_HUNT;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx_byte == CODE_DLE)
                        begin
                            phase_next = PH_STX;
                        end
                    end
                    PH_STX:
                    begin
                        if (rx_byte == CODE_STX)
                        begin
                            phase_next = PH_DATA;
                            count_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_DATA:
                    begin
                        if (rx_byte == CODE_DLE)
                        begin
                            phase_next = PH_ESC;
                        end
                        else
                        begin
                            store = 1'b1;
                        end
                    end
                    PH_ESC:
                    begin
                        phase_next = PH_DATA;
                        if (rx_byte == CODE_ETX)
                        begin
                            drain_req.start = 1'b1;
                            phase_next      = PH_HUNT;
                        end
                        else if (rx_byte == CODE_DLE)
                        begin
                            store = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
                // store full drops the frame
                if (store)
                begin
                    if (count_reg >= MAX_COUNT)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/dsefr_drain.sv -----
// drain sequencer: reads the stored frame and presents it byte by byte
// depends on dsefr_pkg; reads through the payload ram
`timescale 1ns / 1ps

module dsefr_drain (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dsefr_pkg::drain_req_t        drain_req,
    output logic                         drain_busy,
    output logic                         rd_en,
    output logic [dsefr_pkg::ADDR_W-1:0] rd_addr,
    input  logic [dsefr_pkg::BYTE_W-1:0] rd_data,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [15:0]                  m_axis_tdata,  // out_byte, frame_length, zero pad
    output logic                         m_axis_tlast,  // is_last
    output logic                         m_axis_tuser   // is_empty
);
    import dsefr_pkg::*;

    drain_state_t     state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic             empty_reg, empty_next;
    logic [CNT_W-1:0] idx_inc;

    assign idx_inc = idx_reg + CNT_W'(1);
    assign rd_addr = idx_reg[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DR_IDLE;
            idx_reg   <= '0;
            len_reg   <= '0;
            empty_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            empty_reg <= empty_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        empty_next    = empty_reg;
        rd_en         = 1'b0;
        m_axis_tvalid = 1'b0;
        drain_busy    = (state_reg != DR_IDLE);
        m_axis_tdata  = {1'b0, len_reg, (empty_reg ? {BYTE_W{1'b0}} : rd_data)};
        m_axis_tlast  = empty_reg || (idx_inc == len_reg);
        m_axis_tuser  = empty_reg;
        unique case (state_reg)
            DR_IDLE:
            begin
                if (drain_req.start)
                begin
                    idx_next   = '0;
                    len_next   = drain_req.len;
                    empty_next = (drain_req.len == '0);
                    state_next = (drain_req.len == '0) ? DR_SHOW : DR_READ;
                end
            end
            DR_READ:
            begin
                rd_en      = 1'b1;
                state_next = DR_SHOW;
            end
            DR_SHOW:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    if (m_axis_tlast)
                    begin
                        state_next = DR_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = DR_READ;
                    end
                end
            end
            default:
            begin
                state_next = DR_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/dsefr_checker.sv -----
// port-level checks of the frame receiver, bound to the top level
// depends on dle_stx_etx_frame_receiver_defines.svh
`timescale 1ns / 1ps
`include "dle_stx_etx_frame_receiver_defines.svh"

module dsefr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // held output item keeps its payload
    `DSEFR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output item changed while stalled")

    // input is stalled while a frame drains
    `DSEFR_ASSERT_NOW(a_no_overlap, m_axis_tvalid, !s_axis_tready, "input ready during frame output")

    // empty marker is a single zero item
    `DSEFR_ASSERT_NOW(a_empty_form, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == 16'd0), "malformed empty frame marker")

    // each output item is followed by a read cycle or idle
    `DSEFR_ASSERT_NEXT(a_out_gap, m_axis_tvalid && m_axis_tready, !m_axis_tvalid, "output item without ram read cycle")

endmodule

bind dle_stx_etx_frame_receiver dsefr_checker u_checker (.*);
